>>> hdl/ecc_pkg.sv
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types and constants for the elevator car controller: state codes,
// request and heading codes, register indexes and the state/word structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ecc_pkg;

  localparam int unsigned MaxFloors = 64;
  localparam int unsigned FloorW    = 6;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned ProgW     = FracBits + 1;
  localparam int unsigned StepW     = 9;
  localparam int unsigned SumW      = ((ProgW > StepW) ? ProgW : StepW) + 1;
  localparam int unsigned CntW      = $clog2(MaxFloors + 1);

  localparam logic [SumW-1:0] OneFloor = SumW'(1) << FracBits;

  localparam logic [FloorW-1:0] TopFloorRst = FloorW'(9);
  localparam logic [StepW-1:0]  MoveStepRst = StepW'(26);

  // request codes
  localparam logic [1:0] ReqTick  = 2'd0;
  localparam logic [1:0] ReqPress = 2'd1;
  localparam logic [1:0] ReqStart = 2'd2;
  localparam logic [1:0] ReqOpen  = 2'd3;

  // start direction codes
  localparam logic [1:0] DirDown = 2'd0;
  localparam logic [1:0] DirUp   = 2'd1;

  // heading codes
  localparam logic [1:0] HdIdle = 2'd0;
  localparam logic [1:0] HdUp   = 2'd1;
  localparam logic [1:0] HdDown = 2'd2;
  localparam logic [1:0] HdBad  = 2'd3;

  // move state codes as reported
  localparam logic [1:0] MvIdle    = 2'd0;
  localparam logic [1:0] MvMoving  = 2'd1;
  localparam logic [1:0] MvStopped = 2'd2;

  // register indexes
  localparam logic RegTopFloor = 1'b0;
  localparam logic RegMoveStep = 1'b1;

  typedef enum logic [2:0] {
    MsIdle    = 3'b001,
    MsMoving  = 3'b010,
    MsStopped = 3'b100
  } motion_e;

  typedef struct packed {
    motion_e               motion;
    logic [1:0]            heading;
    logic [FloorW-1:0]     floor_now;
    logic [ProgW-1:0]      progress;
    logic [MaxFloors-1:0]  pending;
    logic [CntW-1:0]       pend_cnt;
  } car_state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [FloorW-1:0] floor;
    logic [1:0]        direction;
    logic              door_closed;
  } item_t;

  typedef struct packed {
    logic [1:0]        move_state;
    logic [FloorW-1:0] current_floor;
    logic [1:0]        travel_direction;
    logic              door_open_cmd;
    logic              floor_reached;
    logic              car_request;
    logic              start_refused;
  } result_t;

  typedef struct packed {
    logic [FloorW-1:0] top_floor;
    logic [StepW-1:0]  move_step;
  } cfg_t;

endpackage

`default_nettype wire

>>> hdl/ecc_step.sv
// ----------------------------------------------------------------------------
// ecc_step
// Next-state and result logic for one word: tick, floor press, start request
// or door-open request applied to the car state.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_step (
  input  ecc_pkg::car_state_t cur_i,
  input  ecc_pkg::cfg_t       cfg_i,
  input  ecc_pkg::item_t      item_i,
  output ecc_pkg::car_state_t nxt_o,
  output ecc_pkg::result_t    res_o
);
  import ecc_pkg::*;

  function automatic car_state_t car_stop(car_state_t s, logic [FloorW-1:0] top);
    car_state_t r;
    r = s;
    if (s.pend_cnt == '0) begin
      r.motion  = MsIdle;
      r.heading = HdIdle;
    end else begin
      r.motion = MsStopped;
      if (s.floor_now == top) begin
        r.heading = HdDown;
      end else if (s.floor_now == '0) begin
        r.heading = HdUp;
      end
    end
    return r;
  endfunction

  function automatic logic start_refused(logic [1:0] hd, logic [FloorW-1:0] fl,
                                         logic [FloorW-1:0] top);
    logic bad;
    bad = 1'b1;
    if (hd == HdDown) begin
      bad = (fl == '0);
    end else if (hd == HdUp) begin
      bad = (fl == top);
    end
    return bad;
  endfunction

  logic [SumW-1:0]   sum;
  logic [FloorW-1:0] next_floor;
  logic [FloorW-1:0] idx;
  logic              pend_bit;
  logic [1:0]        start_hd;
  car_state_t        s;
  logic              door_open, reached, added, refused;

  assign sum        = SumW'(cur_i.progress) + SumW'(cfg_i.move_step);
  assign next_floor = (cur_i.heading == HdDown) ? cur_i.floor_now - FloorW'(1)
                                                : cur_i.floor_now + FloorW'(1);
  assign idx        = (item_i.req_type == ReqTick) ? next_floor : item_i.floor;
  assign pend_bit   = cur_i.pending[idx];
  assign start_hd   = (item_i.direction == DirDown) ? HdDown :
                      (item_i.direction == DirUp)   ? HdUp   : HdBad;

  always_comb begin
    s         = cur_i;
    door_open = 1'b0;
    reached   = 1'b0;
    added     = 1'b0;
    refused   = 1'b0;
    unique case (item_i.req_type)
      ReqTick: begin
        if (cur_i.motion == MsMoving) begin
          if (sum >= OneFloor) begin
            s.progress  = '0;
            s.floor_now = next_floor;
            reached     = 1'b1;
            if (pend_bit) begin
              s.pending[idx] = 1'b0;
              s.pend_cnt     = cur_i.pend_cnt - CntW'(1);
              s              = car_stop(s, cfg_i.top_floor);
              door_open      = 1'b1;
            end else if (next_floor == cfg_i.top_floor || next_floor == '0) begin
              s         = car_stop(s, cfg_i.top_floor);
              door_open = 1'b1;
            end
          end else begin
            s.progress = sum[ProgW-1:0];
          end
        end else if (cur_i.motion == MsStopped && item_i.door_closed) begin
          refused = start_refused(cur_i.heading, cur_i.floor_now, cfg_i.top_floor);
          if (!refused) begin
            s.motion = MsMoving;
          end
        end
      end
      ReqPress: begin
        if (item_i.floor == cur_i.floor_now) begin
          s         = car_stop(s, cfg_i.top_floor);
          door_open = 1'b1;
        end else if (!pend_bit) begin
          s.pending[idx] = 1'b1;
          s.pend_cnt     = cur_i.pend_cnt + CntW'(1);
          added          = 1'b1;
        end
      end
      ReqStart: begin
        refused = start_refused(start_hd, cur_i.floor_now, cfg_i.top_floor);
        if (!refused) begin
          s.heading = start_hd;
          s.motion  = MsMoving;
        end
      end
      ReqOpen: begin
        door_open = (cur_i.motion != MsMoving);
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o = '0;
    unique case (s.motion)
      MsIdle:    res_o.move_state = MvIdle;
      MsMoving:  res_o.move_state = MvMoving;
      MsStopped: res_o.move_state = MvStopped;
      default:   res_o.move_state = MvIdle;
    endcase
    res_o.current_floor    = s.floor_now;
    res_o.travel_direction = s.heading;
    res_o.door_open_cmd    = door_open;
    res_o.floor_reached    = reached;
    res_o.car_request      = added;
    res_o.start_refused    = refused;
  end

  assign nxt_o = s;

endmodule

`default_nettype wire

>>> hdl/elevator_car_controller.sv
// ----------------------------------------------------------------------------
// elevator_car_controller
// Single elevator car: move state, heading, floor, travel progress and the
// set of pending destination floors, driven by one request word at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request word: a tick,
//   a destination press, a start request or a door-open request. Output
//   channel (out_valid_o/out_ready_i) returns exactly one result word per
//   request: move state, floor, heading and event flags.
//   out_valid_o rises in the cycle after acceptance. One word is taken
//   every cycle while results are taken; the car state is updated in a
//   single pass of logic and the result lands in the output register.
//   When the receiver stalls, the result holds in the output register and
//   the input keeps accepting only in the cycle the result is taken.
//   The APB port writes top_floor (0x0) and move_step (0x4); pready is
//   always high. Write registers only while no word is in flight.
//   Reset: car idle at floor zero, heading idle, progress zero, no pending
//   floors, top_floor 9, move_step 26. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module elevator_car_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [ecc_pkg::FloorW-1:0] floor_i,
  input  logic [1:0]  direction_i,
  input  logic        door_closed_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  move_state_o,
  output logic [ecc_pkg::FloorW-1:0] current_floor_o,
  output logic [1:0]  travel_direction_o,
  output logic        door_open_cmd_o,
  output logic        floor_reached_o,
  output logic        car_request_o,
  output logic        start_refused_o
);
  import ecc_pkg::*;

  cfg_t       cfg_q;
  car_state_t st_q, st_d;
  item_t      item;
  result_t    res_d, res_q;
  logic       out_valid_q;
  logic       in_fire, cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.top_floor <= TopFloorRst;
      cfg_q.move_step <= MoveStepRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegTopFloor: cfg_q.top_floor <= pwdata[FloorW-1:0];
        RegMoveStep: cfg_q.move_step <= pwdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegTopFloor: prdata = 32'(cfg_q.top_floor);
      RegMoveStep: prdata = 32'(cfg_q.move_step);
      default:     prdata = '0;
    endcase
  end

  // request path
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign item.req_type    = req_type_i;
  assign item.floor       = floor_i;
  assign item.direction   = direction_i;
  assign item.door_closed = door_closed_i;

  ecc_step u_step (
    .cur_i  (st_q),
    .cfg_i  (cfg_q),
    .item_i (item),
    .nxt_o  (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.motion    <= MsIdle;
      st_q.heading   <= HdIdle;
      st_q.floor_now <= '0;
      st_q.progress  <= '0;
      st_q.pending   <= '0;
      st_q.pend_cnt  <= '0;
    end else if (in_fire) begin
      st_q <= st_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign move_state_o       = res_q.move_state;
  assign current_floor_o    = res_q.current_floor;
  assign travel_direction_o = res_q.travel_direction;
  assign door_open_cmd_o    = res_q.door_open_cmd;
  assign floor_reached_o    = res_q.floor_reached;
  assign car_request_o      = res_q.car_request;
  assign start_refused_o    = res_q.start_refused;

`ifndef NO_ASSERTIONS
  a_fire_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted word did not produce a result");

  a_pend_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.pend_cnt == CntW'($countones(st_q.pending)))
    else $error("pending count out of step with pending set");

  a_moving_heading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.motion == MsMoving) |-> (st_q.heading == HdUp || st_q.heading == HdDown))
    else $error("car moving without a heading");

  a_reach_resets_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_d.floor_reached) |=> (st_q.progress == '0))
    else $error("progress not cleared on floor arrival");
`endif

endmodule

`default_nettype wire

>>> tb/tb_elevator_car_controller.sv
// ----------------------------------------------------------------------------
// tb_elevator_car_controller
// Self-checking bench for the elevator car controller. Request words go in
// through a bursty valid/ready sender while the result side stalls on its
// own pattern. Every result word is compared field by field against a
// behavioral model of the car that runs alongside. Directed stop, refusal
// and restart cases come first. Random traffic then runs under several
// register settings, a long output stall and a full-rate stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_elevator_car_controller;
  import ecc_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned LongHold   = 80;
  localparam int unsigned PrintLimit = 40;

  localparam logic [1:0] DirOther = 2'd2;
  localparam logic [1:0] DirSpare = 2'd3;

  typedef enum int {RxFree, RxCoin, RxBlock, RxThird} rx_pattern_e;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [2:0]        paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [1:0]        req_type_i    = '0;
  logic [FloorW-1:0] floor_i       = '0;
  logic [1:0]        direction_i   = '0;
  logic              door_closed_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [1:0]        move_state_o;
  logic [FloorW-1:0] current_floor_o;
  logic [1:0]        travel_direction_o;
  logic              door_open_cmd_o;
  logic              floor_reached_o;
  logic              car_request_o;
  logic              start_refused_o;

  elevator_car_controller DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .req_type_i(req_type_i),
    .floor_i(floor_i),
    .direction_i(direction_i),
    .door_closed_i(door_closed_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .move_state_o(move_state_o),
    .current_floor_o(current_floor_o),
    .travel_direction_o(travel_direction_o),
    .door_open_cmd_o(door_open_cmd_o),
    .floor_reached_o(floor_reached_o),
    .car_request_o(car_request_o),
    .start_refused_o(start_refused_o)
  );

  // car model state
  logic [1:0]           car_motion  = MvIdle;
  logic [1:0]           car_heading = HdIdle;
  logic [FloorW-1:0]    car_floor   = '0;
  logic [ProgW-1:0]     car_progress = '0;
  logic [MaxFloors-1:0] car_pending = '0;
  logic [FloorW-1:0]    cfg_top     = TopFloorRst;
  logic [StepW-1:0]     cfg_step    = MoveStepRst;

  result_t predicted_status[$];

  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned settings_done = 0;
  int unsigned mismatches    = 0;
  int unsigned burst_left    = 0;
  int unsigned idle_cycles   = 0;
  bit          gapless       = 1'b0;
  bit          rx_free_run   = 1'b0;
  bit          hold_request  = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < PrintLimit) begin
      $display("mismatch %s: got %0d expected %0d (result word %0d)",
               what, got, want, words_checked);
    end
    mismatches++;
  endtask

  function automatic void car_halt();
    if (car_pending == '0) begin
      car_motion  = MvIdle;
      car_heading = HdIdle;
    end else begin
      car_motion = MvStopped;
      if (car_floor == cfg_top) begin
        car_heading = HdDown;
      end else if (car_floor == '0) begin
        car_heading = HdUp;
      end
    end
  endfunction

  function automatic logic car_launch(logic [1:0] hd);
    if (hd == HdDown && car_floor == '0) return 1'b1;
    if (hd == HdUp && car_floor == cfg_top) return 1'b1;
    if (hd != HdDown && hd != HdUp) return 1'b1;
    car_heading = hd;
    car_motion  = MvMoving;
    return 1'b0;
  endfunction

  function automatic void predict_car(item_t w);
    result_t           r;
    logic [SumW-1:0]   sum;
    logic [FloorW-1:0] nxt;
    logic [1:0]        hd;
    r = '0;
    case (w.req_type)
      ReqTick: begin
        if (car_motion == MvMoving) begin
          sum = SumW'(car_progress) + SumW'(cfg_step);
          if (sum >= OneFloor) begin
            car_progress = '0;
            nxt = (car_heading == HdDown) ? car_floor - 1'b1 : car_floor + 1'b1;
            car_floor = nxt;
            r.floor_reached = 1'b1;
            if (car_pending[nxt]) begin
              car_pending[nxt] = 1'b0;
              car_halt();
              r.door_open_cmd = 1'b1;
            end else if (nxt == cfg_top || nxt == '0) begin
              car_halt();
              r.door_open_cmd = 1'b1;
            end
          end else begin
            car_progress = sum[ProgW-1:0];
          end
        end else if (car_motion == MvStopped && w.door_closed) begin
          r.start_refused = car_launch(car_heading);
        end
      end
      ReqPress: begin
        if (w.floor == car_floor) begin
          car_halt();
          r.door_open_cmd = 1'b1;
        end else if (!car_pending[w.floor]) begin
          car_pending[w.floor] = 1'b1;
          r.car_request = 1'b1;
        end
      end
      ReqStart: begin
        hd = (w.direction == DirDown) ? HdDown : (w.direction == DirUp) ? HdUp : HdBad;
        r.start_refused = car_launch(hd);
      end
      ReqOpen: begin
        if (car_motion != MvMoving) r.door_open_cmd = 1'b1;
      end
    endcase
    r.move_state       = car_motion;
    r.current_floor    = car_floor;
    r.travel_direction = car_heading;
    predicted_status.push_back(r);
  endfunction

  task automatic send_word(item_t w);
    int unsigned gap;
    in_valid_i    <= 1'b1;
    req_type_i    <= w.req_type;
    floor_i       <= w.floor;
    direction_i   <= w.direction;
    door_closed_i <= w.door_closed;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_car(w);
    words_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !gapless) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_fields(logic [1:0] req, logic [FloorW-1:0] fl, logic [1:0] dir,
                             logic closed);
    item_t w;
    w.req_type    = req;
    w.floor       = fl;
    w.direction   = dir;
    w.door_closed = closed;
    send_word(w);
  endtask

  function automatic item_t random_word();
    item_t       w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      w.req_type = ReqTick;
    end else if (pick < 75) begin
      w.req_type = ReqPress;
    end else if (pick < 90) begin
      w.req_type = ReqStart;
    end else begin
      w.req_type = ReqOpen;
    end
    if ($urandom_range(0, 3) != 0) begin
      w.floor = FloorW'($urandom_range(0, cfg_top));
    end else begin
      w.floor = FloorW'($urandom);
    end
    if ($urandom_range(0, 7) == 0) begin
      w.direction = 2'($urandom_range(2, 3));
    end else begin
      w.direction = 2'($urandom_range(0, 1));
    end
    w.door_closed = ($urandom_range(0, 9) != 0);
    return w;
  endfunction

  task automatic send_random(int unsigned count);
    repeat (count) send_word(random_word());
  endtask

  task automatic settle_car();
    in_valid_i <= 1'b0;
    while (predicted_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic reg_idx, logic [31:0] data);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (reg_idx == RegTopFloor) begin
      cfg_top = data[FloorW-1:0];
    end else begin
      cfg_step = data[StepW-1:0];
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    want = (reg_idx == RegTopFloor) ? 32'(cfg_top) : 32'(cfg_step);
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_car(logic [FloorW-1:0] top, logic [StepW-1:0] step);
    logic [31:0] junk;
    junk = $urandom;
    cfg_write(RegTopFloor, {junk[31:FloorW], top});
    junk = $urandom;
    cfg_write(RegMoveStep, {junk[31:StepW], step});
    settings_done++;
  endtask

  task automatic test_reset_defaults();
    send_fields(ReqOpen, 0, DirDown, 1'b1);
    send_fields(ReqTick, 0, DirDown, 1'b1);
    send_fields(ReqPress, 0, DirDown, 1'b1);
    send_fields(ReqStart, 0, DirDown, 1'b1);
    send_fields(ReqStart, 0, DirOther, 1'b1);
    send_fields(ReqStart, 0, DirSpare, 1'b0);
    send_fields(ReqPress, 2, DirDown, 1'b1);
    send_fields(ReqPress, 2, DirUp, 1'b1);
    send_fields(ReqStart, 0, DirUp, 1'b1);
    send_fields(ReqOpen, 0, DirUp, 1'b1);
    send_fields(ReqTick, 0, DirUp, 1'b1);
    send_fields(ReqTick, 0, DirUp, 1'b1);
  endtask

  task automatic test_stop_and_restart();
    settle_car();
    program_car(TopFloorRst, 256);
    send_fields(ReqTick, 0, DirUp, 1'b1);
    send_fields(ReqTick, 0, DirUp, 1'b1);
    send_fields(ReqPress, 5, DirUp, 1'b1);
    send_fields(ReqPress, 63, DirUp, 1'b1);
    // stop at the current floor with an idle heading
    send_fields(ReqPress, 2, DirUp, 1'b1);
    send_fields(ReqTick, 0, DirUp, 1'b1);
    send_fields(ReqTick, 0, DirUp, 1'b0);
    send_fields(ReqOpen, 0, DirUp, 1'b0);
    send_fields(ReqStart, 0, DirUp, 1'b1);
    send_fields(ReqTick, 0, DirUp, 1'b1);
  endtask

  task automatic test_random_settings();
    int unsigned top_set[9];
    int unsigned step_set[9];
    int unsigned i;
    top_set  = '{9, 63, 1, 5, 20, 63, 0, 33, 0};
    step_set = '{128, 256, 256, 77, 511, 1, 200, 0, 0};
    top_set[8]  = $urandom_range(1, 63);
    step_set[8] = $urandom_range(1, 256);
    for (i = 0; i < 9; i++) begin
      settle_car();
      program_car(FloorW'(top_set[i]), StepW'(step_set[i]));
      send_random((step_set[i] == 0) ? 60 : 160);
    end
  endtask

  task automatic test_output_backpressure();
    settle_car();
    program_car(63, 256);
    gapless = 1'b1;
    hold_request = 1'b1;
    send_random(150);
    gapless = 1'b0;
  endtask

  task automatic test_full_rate();
    settle_car();
    program_car(9, 128);
    gapless = 1'b1;
    rx_free_run = 1'b1;
    send_random(100);
    gapless = 1'b0;
    rx_free_run = 1'b0;
  endtask

  initial begin : rx_proc
    rx_pattern_e pat;
    int unsigned left;
    int unsigned hold;
    int unsigned cyc;
    pat  = RxFree;
    left = 0;
    hold = 0;
    cyc  = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold = LongHold;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (rx_free_run) begin
        out_ready_i <= 1'b1;
      end else begin
        if (left == 0) begin
          pat  = rx_pattern_e'($urandom_range(0, 3));
          left = (pat == RxBlock) ? $urandom_range(1, 6) : $urandom_range(4, 40);
        end
        left--;
        case (pat)
          RxFree:  out_ready_i <= 1'b1;
          RxCoin:  out_ready_i <= 1'($urandom_range(0, 1));
          RxBlock: out_ready_i <= 1'b0;
          default: out_ready_i <= (cyc % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {move_state_o, current_floor_o, travel_direction_o, door_open_cmd_o,
             floor_reached_o, car_request_o, start_refused_o};
      if (predicted_status.size() == 0) begin
        report_mismatch("result word with nothing pending", got, 0);
      end else begin
        want = predicted_status.pop_front();
        if (got.move_state !== want.move_state)
          report_mismatch("move_state", got.move_state, want.move_state);
        if (got.current_floor !== want.current_floor)
          report_mismatch("current_floor", got.current_floor, want.current_floor);
        if (got.travel_direction !== want.travel_direction)
          report_mismatch("travel_direction", got.travel_direction, want.travel_direction);
        if (got.door_open_cmd !== want.door_open_cmd)
          report_mismatch("door_open_cmd", got.door_open_cmd, want.door_open_cmd);
        if (got.floor_reached !== want.floor_reached)
          report_mismatch("floor_reached", got.floor_reached, want.floor_reached);
        if (got.car_request !== want.car_request)
          report_mismatch("car_request", got.car_request, want.car_request);
        if (got.start_refused !== want.start_refused)
          report_mismatch("start_refused", got.start_refused, want.start_refused);
        words_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               idle_cycles, predicted_status.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_stop_and_restart();
    test_random_settings();
    test_output_backpressure();
    test_full_rate();
    settle_car();
    $display("%0d request words sent and %0d result words compared over %0d register settings,",
             words_sent, words_checked, settings_done);
    $display("with directed stop and refusal cases, a long output stall and a full-rate run");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hdl/ecc_pkg.sv
hdl/ecc_step.sv
hdl/elevator_car_controller.sv
tb/tb_elevator_car_controller.sv
